FILE: rtl/lbp_pkg.sv
// shared constants, types and build-time geometry helpers for the lbp stream block
package lbp_pkg;

    // parameter defaults
    localparam int RADIUS_DEFAULT    = 1;
    localparam int POINTS_DEFAULT    = 8;
    localparam int MAX_WIDTH_DEFAULT = 1024;

    // fixed field widths
    localparam int PIXEL_W    = 8;
    localparam int CODE_W     = 8;
    localparam int COUNT_W    = 10;
    localparam int WIDTH_W    = 11;
    localparam int CFG_ADDR_W = 4;

    // counters are 10 bits, so the row length in use never exceeds this
    localparam int WIDTH_LIMIT = 1024;

    // reset value of the row length register
    localparam logic [WIDTH_W-1:0] IMAGE_WIDTH_RESET = 11'd640;

    // uniform mapping
    localparam int LABEL_NONUNIFORM = 5;
    localparam int MAX_TRANSITIONS  = 2;

    // arithmetic widths of the interpolation datapath
    localparam int MUL_W  = 25;
    localparam int PROD_W = 24;
    localparam int SUM_W  = 26;

    // result queue
    localparam int QDEPTH = 8;
    localparam int QPTR_W = 3;

    // fixed point angle constants, Q2.30
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;

    // configuration register addresses
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_UNIFORM_MODE = 4'd0,
        CFG_IMAGE_WIDTH  = 4'd1
    } cfg_reg_t;

    // one finished result
    typedef struct packed {
        logic [CODE_W-1:0]  code;
        logic [COUNT_W-1:0] row;
        logic [COUNT_W-1:0] col;
    } lbp_result_t;

    // sine of phi in Q2.30 by taylor series, first quadrant, build time only
    function automatic logic [63:0] sin_q30(input logic [63:0] phi);
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] acc;
        x2   = (phi * phi) >> 30;
        term = phi;
        acc  = signed'(phi);
        for (int k = 1; k <= 7; k++)
        begin
            term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
            if ((k % 2) == 1)
                acc = acc - signed'(term);
            else
                acc = acc + signed'(term);
        end
        return (acc < 0) ? 64'd0 : unsigned'(acc);
    endfunction

    // cosine of phi in Q2.30 by taylor series, first quadrant, build time only
    function automatic logic [63:0] cos_q30(input logic [63:0] phi);
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] acc;
        x2   = (phi * phi) >> 30;
        term = ONE_Q30;
        acc  = signed'(ONE_Q30);
        for (int k = 1; k <= 7; k++)
        begin
            term = ((term * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
            if ((k % 2) == 1)
                acc = acc - signed'(term);
            else
                acc = acc + signed'(term);
        end
        return (acc < 0) ? 64'd0 : unsigned'(acc);
    endfunction

    // scale a Q2.30 magnitude by the radius and round to Q.8, half away from zero
    function automatic int to_q8(input logic [63:0] mag, input bit neg, input int radius);
        logic [63:0] scaled;
        int          m;
        scaled = ((64'(radius) * mag * 64'd256) + (64'd1 << 29)) >> 30;
        m      = int'(scaled);
        return neg ? -m : m;
    endfunction

endpackage

FILE: rtl/lbp_pixel_if.sv
// pixel input channel with valid/ready handshake
interface lbp_pixel_if;
    logic                        valid;
    logic                        ready;
    logic [lbp_pkg::PIXEL_W-1:0] pixel;
    logic                        first_of_frame;

    modport source (output valid, pixel, first_of_frame, input ready);
    modport sink   (input valid, pixel, first_of_frame, output ready);
endinterface

FILE: rtl/lbp_code_if.sv
// pattern code output channel with valid/ready handshake
interface lbp_code_if;
    logic                        valid;
    logic                        ready;
    logic [lbp_pkg::CODE_W-1:0]  pattern_code;
    logic [lbp_pkg::COUNT_W-1:0] center_row;
    logic [lbp_pkg::COUNT_W-1:0] center_col;

    modport source (output valid, pattern_code, center_row, center_col, input ready);
    modport sink   (input valid, pattern_code, center_row, center_col, output ready);
endinterface

FILE: rtl/lbp_cfg_if.sv
// configuration write channel with valid/ready handshake
interface lbp_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [lbp_pkg::CFG_ADDR_W-1:0] addr;
    logic [lbp_pkg::WIDTH_W-1:0]    data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

FILE: rtl/local_binary_pattern_image_stream.sv
// Streaming local binary pattern: takes one pixel per clock in raster order and
// returns one code per interior center. The last 2*RADIUS+1 rows live in a single
// line memory with one word per column that packs all rows; every request reads
// that word, swaps in the new pixel and writes it back in the following cycle. The memory
// has one read port and one write port, so a read and the write back of the
// previous request share a cycle and the rate stays at one pixel per clock.
// The result of the pixel that completes a window passes stages a, b, c and d and
// then enters an eight-entry queue, where it waits; the input request is held off
// only while eight results are in flight or queued. The line memory needs no
// clearing after reset. Configuration writes are taken in any cycle and should be
// issued only while no pixels are in flight.
module local_binary_pattern_image_stream #(
    parameter int RADIUS    = lbp_pkg::RADIUS_DEFAULT,
    parameter int POINTS    = lbp_pkg::POINTS_DEFAULT,
    parameter int MAX_WIDTH = lbp_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    lbp_pixel_if.sink   pixels,
    lbp_code_if.source  codes,
    lbp_cfg_if.sink     cfg
);

    localparam int SPAN       = 2 * RADIUS + 1;
    localparam int SLOT_W     = $clog2(SPAN);
    localparam int MEM_DEPTH  = (MAX_WIDTH < lbp_pkg::WIDTH_LIMIT) ? MAX_WIDTH
                                                                   : lbp_pkg::WIDTH_LIMIT;
    localparam int ADDR_W     = $clog2(MEM_DEPTH);
    localparam int WORD_W     = SPAN * lbp_pkg::PIXEL_W;
    localparam int PW         = lbp_pkg::PIXEL_W;
    localparam int CW         = lbp_pkg::COUNT_W;
    localparam int QW         = lbp_pkg::QPTR_W;

    localparam logic [lbp_pkg::WIDTH_W-1:0] WIDTH_CAP = lbp_pkg::WIDTH_W'(MEM_DEPTH);
    localparam logic [CW-1:0]               BORDER    = CW'(2 * RADIUS);
    localparam logic [CW-1:0]               OFFSET    = CW'(RADIUS);
    localparam logic [CW-1:0]               ROW_LAST  = {CW{1'b1}};
    localparam logic [SLOT_W-1:0]           SLOT_LAST = SLOT_W'(SPAN - 1);

    // configuration registers
    logic                          uniform_mode_reg;
    logic [lbp_pkg::WIDTH_W-1:0]   image_width_reg;

    // position counters
    logic [CW-1:0]     col_reg, col_next;
    logic [CW-1:0]     row_reg, row_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;

    // request side
    logic                          accept;
    logic                          emit;
    logic [CW-1:0]                 col_cur, row_cur;
    logic [SLOT_W-1:0]             slot_cur;
    logic [lbp_pkg::WIDTH_W-1:0]   width_use;
    logic                          row_end;
    logic [ADDR_W-1:0]             rd_addr;

    // line memory
    logic [WORD_W-1:0] line_mem [MEM_DEPTH];
    logic [WORD_W-1:0] rdata_reg;
    logic [WORD_W-1:0] wr_hold_reg;

    // stage a: memory word arrives, merge and write back
    logic              a_valid_reg;
    logic              a_emit_reg;
    logic              a_fwd_reg;
    logic [PW-1:0]     a_pixel_reg;
    logic [ADDR_W-1:0] a_addr_reg;
    logic [SLOT_W-1:0] a_slot_reg;
    logic [CW-1:0]     a_row_reg, a_col_reg;
    logic [WORD_W-1:0] base_word;
    logic [PW-1:0]     merged_lane [SPAN];
    logic [WORD_W-1:0] merged_word;
    logic [PW-1:0]     new_col [SPAN];

    // window
    logic [PW-1:0] win_reg  [SPAN][SPAN];
    logic [PW-1:0] win_next [SPAN][SPAN];

    // stage b: window ready, products formed
    logic          b_valid_reg;
    logic [CW-1:0] b_row_reg, b_col_reg;
    logic [lbp_pkg::PROD_W-1:0] prod_next [POINTS][4];

    // stage c: products held, sums compared
    logic                       c_valid_reg;
    logic [CW-1:0]              c_row_reg, c_col_reg;
    logic [lbp_pkg::PROD_W-1:0] prod_reg [POINTS][4];
    logic [PW-1:0]              c_center_reg;
    logic [POINTS-1:0]          code_next;

    // stage d: raw code held, uniform mapping on push
    logic              d_valid_reg;
    logic [CW-1:0]     d_row_reg, d_col_reg;
    logic [POINTS-1:0] d_code_reg;
    logic [POINTS-1:0] code_rot;
    logic [POINTS-1:0] code_mapped;
    logic [POINTS+PW-1:0] code_wide;
    logic              nonuniform;
    lbp_pkg::lbp_result_t push_entry;

    // result queue and credits
    lbp_pkg::lbp_result_t q_mem [lbp_pkg::QDEPTH];
    logic [QW-1:0] q_wr_ptr_reg, q_rd_ptr_reg;
    logic [QW:0]   q_count_reg;
    logic [QW:0]   credit_reg, credit_next;
    logic          pop;

    // configuration writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            uniform_mode_reg <= 1'b0;
            image_width_reg  <= lbp_pkg::IMAGE_WIDTH_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.addr)
                lbp_pkg::CFG_UNIFORM_MODE: uniform_mode_reg <= cfg.data[0];
                lbp_pkg::CFG_IMAGE_WIDTH:  image_width_reg  <= cfg.data;
                default: ;
            endcase
        end
    end

    // request handshake
    assign pixels.ready = (credit_reg < (QW + 1)'(lbp_pkg::QDEPTH));
    assign accept       = pixels.valid && pixels.ready;

    // position of the incoming pixel and counter advance
    always_comb
    begin
        col_cur   = pixels.first_of_frame ? '0 : col_reg;
        row_cur   = pixels.first_of_frame ? '0 : row_reg;
        slot_cur  = pixels.first_of_frame ? '0 : slot_reg;
        width_use = (image_width_reg > WIDTH_CAP) ? WIDTH_CAP : image_width_reg;
        row_end   = (({1'b0, col_cur} + 1'b1) >= width_use);
        emit      = (row_cur >= BORDER) && (col_cur >= BORDER);
        rd_addr   = col_cur[ADDR_W-1:0];
        if (row_end)
        begin
            col_next = '0;
            row_next = row_cur + 1'b1;
            if (row_cur == ROW_LAST || slot_cur == SLOT_LAST)
                slot_next = '0;
            else
                slot_next = slot_cur + 1'b1;
        end
        else
        begin
            col_next  = col_cur + 1'b1;
            row_next  = row_cur;
            slot_next = slot_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            slot_reg <= '0;
        end
        else if (accept)
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            slot_reg <= slot_next;
        end
    end

    // line memory read
    always_ff @(posedge clk)
    begin
        if (accept)
            rdata_reg <= line_mem[rd_addr];
    end

    // line memory write back
    always_ff @(posedge clk)
    begin
        if (a_valid_reg)
            line_mem[a_addr_reg] <= merged_word;
    end

    // stage a control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else
            a_valid_reg <= accept;
    end

    // stage a payload; forward when the word being written is read in the same cycle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_emit_reg  <= emit;
            a_fwd_reg   <= a_valid_reg && (a_addr_reg == rd_addr);
            a_pixel_reg <= pixels.pixel;
            a_addr_reg  <= rd_addr;
            a_slot_reg  <= slot_cur;
            a_row_reg   <= row_cur - OFFSET;
            a_col_reg   <= col_cur - OFFSET;
        end
        if (a_valid_reg)
            wr_hold_reg <= merged_word;
    end

    // merge the new pixel into its row slot and pick the new window column
    always_comb
    begin
        logic [SLOT_W:0] idx;
        base_word = a_fwd_reg ? wr_hold_reg : rdata_reg;
        for (int s = 0; s < SPAN; s++)
        begin
            if (a_slot_reg == SLOT_W'(s))
                merged_lane[s] = a_pixel_reg;
            else
                merged_lane[s] = base_word[s*PW +: PW];
            merged_word[s*PW +: PW] = merged_lane[s];
        end
        for (int k = 0; k < SPAN; k++)
        begin
            idx = {1'b0, a_slot_reg} + (SLOT_W + 1)'(k + 1);
            if (idx >= (SLOT_W + 1)'(SPAN))
                idx = idx - (SLOT_W + 1)'(SPAN);
            new_col[k] = merged_lane[idx[SLOT_W-1:0]];
        end
    end

    // window shift
    always_comb
    begin
        for (int r = 0; r < SPAN; r++)
        begin
            for (int c = 0; c < SPAN - 1; c++)
                win_next[r][c] = win_reg[r][c+1];
            win_next[r][SPAN-1] = new_col[r];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < SPAN; r++)
                for (int c = 0; c < SPAN; c++)
                    win_reg[r][c] <= '0;
        end
        else if (a_valid_reg)
        begin
            win_reg <= win_next;
        end
    end

    // stage b
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else
            b_valid_reg <= a_valid_reg && a_emit_reg;
    end

    always_ff @(posedge clk)
    begin
        if (a_valid_reg)
        begin
            b_row_reg <= a_row_reg;
            b_col_reg <= a_col_reg;
        end
    end

    // sample geometry per neighbor and its four weighted taps
    for (genvar n = 0; n < POINTS; n++)
    begin : g_point
        localparam int          Q    = 4 * n;
        localparam int          QUAD = (Q / POINTS) % 4;
        localparam int          REM  = Q % POINTS;
        localparam logic [63:0] PHI  = lbp_pkg::HALF_PI_Q30 * 64'(REM) / 64'(POINTS);
        localparam logic [63:0] SV   = lbp_pkg::sin_q30(PHI);
        localparam logic [63:0] CV   = lbp_pkg::cos_q30(PHI);
        localparam logic [63:0] CM   = (QUAD == 0 || QUAD == 2) ? CV : SV;
        localparam logic [63:0] SM   = (QUAD == 0 || QUAD == 2) ? SV : CV;
        localparam bit          CNEG = (QUAD == 1 || QUAD == 2);
        localparam bit          SNEG = (QUAD >= 2);
        localparam int          XQ   = lbp_pkg::to_q8(CM, CNEG, RADIUS);
        localparam int          YQ   = lbp_pkg::to_q8(SM, !SNEG, RADIUS);
        localparam int          FX   = XQ >>> 8;
        localparam int          TX   = XQ & 255;
        localparam int          CX   = FX + ((TX != 0) ? 1 : 0);
        localparam int          FY   = YQ >>> 8;
        localparam int          TY   = YQ & 255;
        localparam int          CY   = FY + ((TY != 0) ? 1 : 0);
        localparam int          W1   = (256 - TX) * (256 - TY);
        localparam int          W2   = TX * (256 - TY);
        localparam int          W3   = (256 - TX) * TY;
        localparam int          W4   = TX * TY;

        assign prod_next[n][0] = lbp_pkg::PROD_W'(
            lbp_pkg::MUL_W'(win_reg[RADIUS+FY][RADIUS+FX]) * lbp_pkg::MUL_W'(W1));
        assign prod_next[n][1] = lbp_pkg::PROD_W'(
            lbp_pkg::MUL_W'(win_reg[RADIUS+FY][RADIUS+CX]) * lbp_pkg::MUL_W'(W2));
        assign prod_next[n][2] = lbp_pkg::PROD_W'(
            lbp_pkg::MUL_W'(win_reg[RADIUS+CY][RADIUS+FX]) * lbp_pkg::MUL_W'(W3));
        assign prod_next[n][3] = lbp_pkg::PROD_W'(
            lbp_pkg::MUL_W'(win_reg[RADIUS+CY][RADIUS+CX]) * lbp_pkg::MUL_W'(W4));
    end

    // stage c
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_valid_reg <= 1'b0;
        else
            c_valid_reg <= b_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (b_valid_reg)
        begin
            prod_reg     <= prod_next;
            c_center_reg <= win_reg[RADIUS][RADIUS];
            c_row_reg    <= b_row_reg;
            c_col_reg    <= b_col_reg;
        end
    end

    // interpolated sample against center, one bit per neighbor
    always_comb
    begin
        logic [lbp_pkg::SUM_W-1:0] sum;
        logic [lbp_pkg::SUM_W-1:0] center_scaled;
        center_scaled = lbp_pkg::SUM_W'({c_center_reg, 16'b0});
        for (int n = 0; n < POINTS; n++)
        begin
            sum = lbp_pkg::SUM_W'(prod_reg[n][0]) + lbp_pkg::SUM_W'(prod_reg[n][1])
                + lbp_pkg::SUM_W'(prod_reg[n][2]) + lbp_pkg::SUM_W'(prod_reg[n][3]);
            code_next[n] = (sum > center_scaled);
        end
    end

    // stage d
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_valid_reg <= 1'b0;
        else
            d_valid_reg <= c_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (c_valid_reg)
        begin
            d_code_reg <= code_next;
            d_row_reg  <= c_row_reg;
            d_col_reg  <= c_col_reg;
        end
    end

    // uniform mapping on the finished code
    always_comb
    begin
        code_rot    = {d_code_reg[0], d_code_reg[POINTS-1:1]};
        nonuniform  = uniform_mode_reg &&
                      ($countones(d_code_reg ^ code_rot) > lbp_pkg::MAX_TRANSITIONS);
        code_mapped = nonuniform ? POINTS'(lbp_pkg::LABEL_NONUNIFORM) : d_code_reg;
        code_wide   = {{PW{1'b0}}, code_mapped};
        push_entry.code = code_wide[PW-1:0];
        push_entry.row  = d_row_reg;
        push_entry.col  = d_col_reg;
    end

    // result queue
    assign pop          = codes.valid && codes.ready;
    assign codes.valid  = (q_count_reg != '0);
    assign codes.pattern_code = q_mem[q_rd_ptr_reg].code;
    assign codes.center_row   = q_mem[q_rd_ptr_reg].row;
    assign codes.center_col   = q_mem[q_rd_ptr_reg].col;

    always_ff @(posedge clk)
    begin
        if (d_valid_reg)
            q_mem[q_wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wr_ptr_reg <= '0;
            q_rd_ptr_reg <= '0;
            q_count_reg  <= '0;
        end
        else
        begin
            if (d_valid_reg)
                q_wr_ptr_reg <= q_wr_ptr_reg + 1'b1;
            if (pop)
                q_rd_ptr_reg <= q_rd_ptr_reg + 1'b1;
            q_count_reg <= q_count_reg + (QW + 1)'(d_valid_reg) - (QW + 1)'(pop);
        end
    end

    // credits cover results in the pipeline and in the queue
    assign credit_next = credit_reg + (QW + 1)'(accept && emit) - (QW + 1)'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            credit_reg <= '0;
        else
            credit_reg <= credit_next;
    end

endmodule

FILE: tb/lbp_code_checker.sv
// pattern code checker: tracks the pixel stream, predicts codes and compares returned ones
module lbp_code_checker
    import lbp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    lbp_pixel_if  pixels,
    lbp_code_if   codes,
    lbp_cfg_if    cfg,
    output int    mismatches,
    output int    outstanding,
    output int    codes_checked,
    output int    labels_remapped
);

    localparam int SPAN        = 3;
    localparam int ROW_SLOTS   = MAX_WIDTH_DEFAULT;
    localparam int MAX_REPORTS = 10;

    // sample geometry for radius 1 and eight points: floor and ceiling offsets
    // of each neighbor plus its Q0.8 fractions, counterclockwise from the right
    localparam int FX [8] = '{1, 0, 0, -1, -1, -1, 0, 0};
    localparam int CX [8] = '{1, 1, 0, 0, -1, 0, 0, 1};
    localparam int FY [8] = '{0, -1, -1, -1, 0, 0, 1, 0};
    localparam int CY [8] = '{0, 0, -1, 0, 0, 1, 1, 1};
    localparam int TX [8] = '{0, 181, 0, 75, 0, 75, 0, 181};
    localparam int TY [8] = '{0, 75, 0, 75, 0, 181, 0, 181};

    // predicted block state and register copies
    logic [PIXEL_W-1:0] line_rows [SPAN*ROW_SLOTS];
    logic [PIXEL_W-1:0] win [SPAN][SPAN];
    int                 col_now;
    int                 row_now;
    bit                 uniform_on;
    logic [WIDTH_W-1:0] row_len;

    lbp_result_t        pending_codes [$];
    lbp_result_t        want;
    int                 bad_results;
    int                 good_count;
    int                 remap_count;

    // code of the current window, with the uniform mapping when enabled
    function automatic logic [CODE_W-1:0] window_pattern();
        logic [CODE_W-1:0] bits;
        logic [CODE_W-1:0] rot;
        logic [63:0]       centre;
        logic [63:0]       acc;
        bits   = '0;
        centre = 64'(win[1][1]) << 16;
        for (int n = 0; n < 8; n++)
        begin
            acc = 64'((256 - TX[n]) * (256 - TY[n])) * win[1 + FY[n]][1 + FX[n]]
                + 64'(TX[n] * (256 - TY[n])) * win[1 + FY[n]][1 + CX[n]]
                + 64'((256 - TX[n]) * TY[n]) * win[1 + CY[n]][1 + FX[n]]
                + 64'(TX[n] * TY[n]) * win[1 + CY[n]][1 + CX[n]];
            if (acc > centre)
                bits[n] = 1'b1;
        end
        if (uniform_on)
        begin
            rot = {bits[0], bits[CODE_W-1:1]};
            if ($countones(bits ^ rot) > MAX_TRANSITIONS)
            begin
                bits = CODE_W'(LABEL_NONUNIFORM);
                remap_count++;
            end
        end
        return bits;
    endfunction

    // advance the predicted state by one accepted pixel request
    function automatic void take_pixel(input logic [PIXEL_W-1:0] value, input logic frame_start);
        int          limit;
        lbp_result_t res;
        if (frame_start)
        begin
            col_now = 0;
            row_now = 0;
        end
        limit = (row_len > WIDTH_LIMIT) ? WIDTH_LIMIT : int'(row_len);
        line_rows[(row_now % SPAN) * ROW_SLOTS + col_now] = value;
        for (int r = 0; r < SPAN; r++)
        begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
        end
        for (int k = 0; k < SPAN; k++)
            win[k][2] = line_rows[((row_now + k + 1) % SPAN) * ROW_SLOTS + col_now];
        if (row_now >= 2 && col_now >= 2)
        begin
            res.code = window_pattern();
            res.row  = COUNT_W'(row_now - 1);
            res.col  = COUNT_W'(col_now - 1);
            pending_codes.insert(pending_codes.size(), res);
        end
        // end of row, with the zero width acting as one
        if (col_now + 1 >= limit)
        begin
            col_now = 0;
            row_now = (row_now + 1) % 1024;
        end
        else
            col_now = col_now + 1;
    endfunction

    // watch the three channels
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < SPAN*ROW_SLOTS; a++)
                line_rows[a] = '0;
            for (int r = 0; r < SPAN; r++)
                for (int c = 0; c < SPAN; c++)
                    win[r][c] = '0;
            col_now     = 0;
            row_now     = 0;
            uniform_on  = 1'b0;
            row_len     = IMAGE_WIDTH_RESET;
            pending_codes.delete();
            bad_results = 0;
            good_count  = 0;
            remap_count = 0;
            mismatches      <= 0;
            outstanding     <= 0;
            codes_checked   <= 0;
            labels_remapped <= 0;
        end
        else
        begin
            // register writes
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.addr == CFG_UNIFORM_MODE)
                    uniform_on = cfg.data[0];
                else if (cfg.addr == CFG_IMAGE_WIDTH)
                    row_len = cfg.data;
            end

            // returned codes against the oldest prediction
            if (codes.valid && codes.ready)
            begin
                if (pending_codes.size() == 0)
                begin
                    bad_results++;
                    if (bad_results <= MAX_REPORTS)
                        $display("unexpected code %02h at row %0d col %0d",
                                 codes.pattern_code, codes.center_row, codes.center_col);
                end
                else
                begin
                    want = pending_codes.pop_front();
                    good_count++;
                    if (want.code !== codes.pattern_code || want.row !== codes.center_row
                        || want.col !== codes.center_col)
                    begin
                        bad_results++;
                        if (bad_results <= MAX_REPORTS)
                            $display({"code mismatch: expected %02h row %0d col %0d, ",
                                      "got %02h row %0d col %0d"},
                                     want.code, want.row, want.col, codes.pattern_code,
                                     codes.center_row, codes.center_col);
                    end
                end
            end

            // accepted pixels
            if (pixels.valid && pixels.ready)
                take_pixel(pixels.pixel, pixels.first_of_frame);

            mismatches      <= bad_results;
            outstanding     <= pending_codes.size();
            codes_checked   <= good_count;
            labels_remapped <= remap_count;
        end
    end

endmodule

FILE: tb/local_binary_pattern_image_stream_test.sv
// top of the lbp stream testbench: clock, reset, pixel and register stimulus, verdict
module local_binary_pattern_image_stream_test;
    import lbp_pkg::*;

    localparam int RANDOM_ITEMS  = 700;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 16;
    localparam int LONG_HOLD     = 400;

    typedef enum int {PIX_NOISE, PIX_FLAT, PIX_BINARY} pixel_style_t;
    typedef enum int {RX_STEADY, RX_COIN, RX_MOSTLY, RX_TRICKLE} rx_style_t;

    // bright ring around a dark center, then a dark row and a bright row
    localparam logic [PIXEL_W-1:0] RING_FRAME [15] = '{
        8'd255, 8'd255, 8'd255,
        8'd255, 8'd0,   8'd255,
        8'd255, 8'd255, 8'd255,
        8'd0,   8'd0,   8'd0,
        8'd255, 8'd255, 8'd255
    };
    // alternating neighbors around a mid gray center give a nonuniform code
    localparam logic [PIXEL_W-1:0] CHECKER_ROWS [9] = '{
        8'd255, 8'd0,   8'd255,
        8'd0,   8'd100, 8'd0,
        8'd255, 8'd0,   8'd255
    };

    logic      clk = 1'b0;
    logic      rst_n;
    logic      rx_ready = 1'b0;
    logic      rx_hold = 1'b0;
    rx_style_t rx_mode = RX_STEADY;
    int        rx_left = 0;
    int        rx_tick = 0;
    bit        hold_go = 1'b0;
    int        cycle_count = 0;
    int        burst_left = 0;
    int        pixels_sent = 0;
    int        random_items = 0;
    int        safe_width = 0;

    int        mismatches;
    int        outstanding;
    int        codes_checked;
    int        labels_remapped;

    lbp_pixel_if pix_ch ();
    lbp_code_if  code_ch ();
    lbp_cfg_if   cfg_ch ();

    assign code_ch.ready = rx_ready;

    local_binary_pattern_image_stream uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pixels (pix_ch),
        .codes  (code_ch),
        .cfg    (cfg_ch)
    );

    lbp_code_checker watcher (
        .clk             (clk),
        .rst_n           (rst_n),
        .pixels          (pix_ch),
        .codes           (code_ch),
        .cfg             (cfg_ch),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .codes_checked   (codes_checked),
        .labels_remapped (labels_remapped)
    );

    // clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timed out after %0d cycles", cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver stall pattern, switching style every so often
    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode <= rx_style_t'($urandom_range(0, 3));
            rx_left <= $urandom_range(10, 150);
        end
        else
            rx_left <= rx_left - 1;
        rx_tick <= rx_tick + 1;
        case (rx_mode)
            RX_STEADY:  rx_ready <= !rx_hold;
            RX_COIN:    rx_ready <= !rx_hold && ($urandom_range(0, 1) == 1);
            RX_MOSTLY:  rx_ready <= !rx_hold && ($urandom_range(0, 3) != 0);
            default:    rx_ready <= !rx_hold && (rx_tick % 4 == 0);
        endcase
    end

    // long receiver hold-off so the result queue fills and the input backs up
    initial
    begin
        wait (hold_go);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // pixel value of a given texture
    function automatic logic [PIXEL_W-1:0] shade(input pixel_style_t style, input int level);
        int v;
        case (style)
            PIX_FLAT:   v = level + int'($urandom_range(0, 6)) - 3;
            PIX_BINARY: v = ($urandom_range(0, 1) == 1) ? 255 : 0;
            default:    v = int'($urandom_range(0, 255));
        endcase
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return PIXEL_W'(v);
    endfunction

    // one pixel request, in bursts with random gaps between them
    task automatic send_pixel(input logic [PIXEL_W-1:0] value, input bit frame_start);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 8));
            burst_left = $urandom_range(1, 48);
            if (gap != 0)
            begin
                pix_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        pix_ch.valid          <= 1'b1;
        pix_ch.pixel          <= value;
        pix_ch.first_of_frame <= frame_start;
        do @(posedge clk); while (!pix_ch.ready);
        pixels_sent++;
    endtask

    // stop sending and wait until every predicted code is back and the pipe is empty
    task automatic settle();
        pix_ch.valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write both registers, back to back
    task automatic set_mode(input bit uniform, input logic [WIDTH_W-1:0] row_len);
        cfg_ch.valid <= 1'b1;
        cfg_ch.addr  <= CFG_UNIFORM_MODE;
        cfg_ch.data  <= WIDTH_W'(uniform);
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.addr  <= CFG_IMAGE_WIDTH;
        cfg_ch.data  <= row_len;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    // main sequence
    initial
    begin
        int           phase;
        int           new_width;
        int           eff;
        int           count;
        int           level;
        bit           fresh;
        bit           uniform;
        bit           mark;
        pixel_style_t style;

        rst_n                 <= 1'b0;
        pix_ch.valid          <= 1'b0;
        pix_ch.pixel          <= '0;
        pix_ch.first_of_frame <= 1'b0;
        cfg_ch.valid          <= 1'b0;
        cfg_ch.addr           <= CFG_UNIFORM_MODE;
        cfg_ch.data           <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: smallest emitting width, extreme pixels, strict compare
        set_mode(1'b0, 11'd3);
        for (int i = 0; i < 15; i++)
            send_pixel(RING_FRAME[i], i == 0);
        settle();
        // uniform mapping, rows continue with no frame mark
        set_mode(1'b1, 11'd3);
        for (int i = 0; i < 9; i++)
            send_pixel(CHECKER_ROWS[i], 1'b0);
        safe_width = 3;

        // random frames of mostly small widths, with narrow widths early on
        phase = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            settle();
            uniform = $urandom_range(0, 1);
            if (phase == 0)
                new_width = 0;
            else if (phase == 1)
                new_width = 2;
            else if (phase == 2)
                new_width = 24;
            else if ($urandom_range(0, 7) == 0)
                new_width = $urandom_range(0, 2);
            else if ($urandom_range(0, 5) == 0)
                new_width = 3;
            else
                new_width = $urandom_range(4, 24);
            eff = (new_width == 0) ? 1 : new_width;
            // a wider row needs a new frame so every stored column is written first
            fresh = (eff > safe_width) || ($urandom_range(0, 2) != 0);
            safe_width = eff;
            set_mode(uniform, WIDTH_W'(new_width));
            count = eff * ((phase == 2) ? 6 : int'($urandom_range(3, 6)))
                  + int'($urandom_range(0, eff - 1));
            style = pixel_style_t'($urandom_range(0, 2));
            level = $urandom_range(0, 255);
            if (phase == 2)
                hold_go = 1'b1;
            for (int i = 0; i < count; i++)
            begin
                mark = (fresh && i == 0) || ($urandom_range(0, 149) == 0);
                send_pixel(shade(style, level), mark);
            end
            random_items += count;
            phase++;
        end

        settle();
        $display("stimulus: %0d pixels, directed ring and checker rows plus %0d random phases",
                 pixels_sent, phase);
        $display("checked %0d codes (%0d nonuniform labels), %0d mismatches, %0d codes missing",
                 codes_checked, labels_remapped, mismatches, outstanding);
        if (mismatches == 0 && outstanding == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
